/* hdl/gha_pkg.sv */
package gha_pkg;

  localparam int unsigned BlockBytes = 16;
  localparam int unsigned BlockBits  = BlockBytes * 8;
  localparam int unsigned HalfBits   = 64;
  localparam int unsigned CntW       = 61;
  localparam int unsigned NbW        = 5;
  localparam int unsigned QueueDepth = 2;

  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};

  localparam logic [1:0] CmdAad     = 2'd0;
  localparam logic [1:0] CmdText    = 2'd1;
  localparam logic [1:0] CmdFinal   = 2'd2;
  localparam logic [1:0] CmdRestart = 2'd3;

  localparam logic [1:0] CfgKeyHigh  = 2'd0;
  localparam logic [1:0] CfgKeyLow   = 2'd1;
  localparam logic [1:0] CfgMaskHigh = 2'd2;
  localparam logic [1:0] CfgMaskLow  = 2'd3;

  typedef struct packed {
    logic [1:0]          command;
    logic [HalfBits-1:0] block_high;
    logic [HalfBits-1:0] block_low;
    logic [NbW-1:0]      byte_count;
  } in_beat_t;

  typedef struct packed {
    logic [HalfBits-1:0] result_high;
    logic [HalfBits-1:0] result_low;
    logic                is_tag;
    logic                length_error;
  } out_beat_t;

  typedef struct packed {
    logic [1:0]           cmd;
    logic [BlockBits-1:0] blk;
    logic [NbW-1:0]       nbytes;
  } op_t;

  // GF(2^128) product in GCM bit order: bit 127 of a vector is the x^0 term.
  function automatic logic [BlockBits-1:0] gf_mul(input logic [BlockBits-1:0] x,
                                                  input logic [BlockBits-1:0] y);
    logic [2*BlockBits-2:0] p;
    logic [BlockBits-2:0]   h;
    logic [BlockBits+7:0]   t;
    logic [7:0]             g;
    logic [BlockBits-1:0]   r;
    logic [BlockBits-1:0]   z;
    int                     j;
    p = '0;
    for (int k = 0; k < 2*BlockBits-1; k++) begin
      for (int i = 0; i < BlockBits; i++) begin
        j = k - i;
        if (j >= 0 && j < BlockBits) begin
          p[k] = p[k] ^ (x[BlockBits-1-i] & y[BlockBits-1-j]);
        end
      end
    end
    h = p[2*BlockBits-2:BlockBits];
    t = {8'd0, p[BlockBits-1:0]} ^ (BlockBits+8)'(h) ^ ((BlockBits+8)'(h) << 1)
      ^ ((BlockBits+8)'(h) << 2) ^ ((BlockBits+8)'(h) << 7);
    g = t[BlockBits+7:BlockBits];
    r = t[BlockBits-1:0] ^ BlockBits'(g) ^ (BlockBits'(g) << 1)
      ^ (BlockBits'(g) << 2) ^ (BlockBits'(g) << 7);
    for (int k = 0; k < BlockBits; k++) begin
      z[BlockBits-1-k] = r[k];
    end
    return z;
  endfunction

endpackage

/* hdl/gha_front.sv */
module gha_front (
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  gha_pkg::in_beat_t  in_data_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output gha_pkg::op_t       q_op_o
);

  logic [gha_pkg::NbW-1:0]       nb;
  logic [gha_pkg::BlockBits-1:0] mask;

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    nb = (in_data_i.byte_count > gha_pkg::NbW'(gha_pkg::BlockBytes)) ?
         gha_pkg::NbW'(gha_pkg::BlockBytes) : in_data_i.byte_count;
    for (int b = 0; b < gha_pkg::BlockBytes; b++) begin
      mask[gha_pkg::BlockBits-1-8*b -: 8] = (gha_pkg::NbW'(b) < nb) ? 8'hff : 8'h00;
    end
    q_op_o.cmd    = in_data_i.command;
    q_op_o.blk    = {in_data_i.block_high, in_data_i.block_low} & mask;
    q_op_o.nbytes = nb;
  end

endmodule

/* hdl/gha_queue.sv */
module gha_queue #(
  parameter int unsigned Depth = gha_pkg::QueueDepth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  gha_pkg::op_t push_op_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         valid_o,
  output gha_pkg::op_t pop_op_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  gha_pkg::op_t    mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o   = (cnt_q == CntW'(Depth));
  assign valid_o  = (cnt_q != '0);
  assign pop_op_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_op_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) full_o |-> !push_i)
    else $error("push into full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) !valid_o |-> !pop_i)
    else $error("pop from empty queue");

endmodule

/* hdl/gha_back.sv */
module gha_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [gha_pkg::HalfBits-1:0] cfg_data_i,
  input  logic                      q_valid_i,
  input  gha_pkg::op_t              q_op_i,
  output logic                      q_pop_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output gha_pkg::out_beat_t        out_data_o
);

  localparam int unsigned HB = gha_pkg::HalfBits;
  localparam int unsigned BB = gha_pkg::BlockBits;
  localparam int unsigned CW = gha_pkg::CntW;

  logic [BB-1:0]       key_q, tmask_q;
  logic [BB-1:0]       acc_q, acc_d;
  logic [CW-1:0]       aad_q, aad_d, txt_q, txt_d;
  logic                ovf_q, ovf_d;
  logic                out_valid_q, out_valid_d;
  gha_pkg::out_beat_t  out_q, out_d;
  logic                fire;
  logic [BB-1:0]       x;
  logic [BB-1:0]       prod;
  logic [CW-1:0]       cnt_sel, cnt_new;
  logic [CW:0]         cnt_sum;

  assign fire        = q_valid_i && (!out_valid_q || !out_stall_i);
  assign q_pop_o     = fire;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    if (q_op_i.cmd == gha_pkg::CmdFinal) begin
      x = acc_q ^ {aad_q, 3'b000, txt_q, 3'b000};
    end else begin
      x = acc_q ^ q_op_i.blk;
    end
  end

  assign prod = gha_pkg::gf_mul(x, key_q);

  always_comb begin
    cnt_sel = (q_op_i.cmd == gha_pkg::CmdText) ? txt_q : aad_q;
    cnt_sum = {1'b0, cnt_sel} + (CW+1)'(q_op_i.nbytes);
    cnt_new = cnt_sum[CW] ? gha_pkg::CntMax : cnt_sum[CW-1:0];
  end

  always_comb begin
    acc_d       = acc_q;
    aad_d       = aad_q;
    txt_d       = txt_q;
    ovf_d       = ovf_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
      unique case (q_op_i.cmd)
        gha_pkg::CmdAad, gha_pkg::CmdText: begin
          acc_d = prod;
          if (q_op_i.cmd == gha_pkg::CmdAad) begin
            aad_d = cnt_new;
          end else begin
            txt_d = cnt_new;
          end
          ovf_d = ovf_q | cnt_sum[CW];
          out_d = '{result_high: prod[BB-1:HB], result_low: prod[HB-1:0],
                    is_tag: 1'b0, length_error: ovf_q | cnt_sum[CW]};
        end
        gha_pkg::CmdFinal: begin
          out_d = '{result_high: prod[BB-1:HB] ^ tmask_q[BB-1:HB],
                    result_low: prod[HB-1:0] ^ tmask_q[HB-1:0],
                    is_tag: 1'b1, length_error: ovf_q};
        end
        gha_pkg::CmdRestart: begin
          acc_d = '0;
          aad_d = '0;
          txt_d = '0;
          ovf_d = 1'b0;
          out_d = '{result_high: '0, result_low: '0, is_tag: 1'b0, length_error: 1'b0};
        end
        default: begin
          out_d = out_q;
        end
      endcase
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q       <= '0;
      tmask_q     <= '0;
      acc_q       <= '0;
      aad_q       <= '0;
      txt_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      aad_q       <= aad_d;
      txt_q       <= txt_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          gha_pkg::CfgKeyHigh:  key_q[BB-1:HB]   <= cfg_data_i;
          gha_pkg::CfgKeyLow:   key_q[HB-1:0]    <= cfg_data_i;
          gha_pkg::CfgMaskHigh: tmask_q[BB-1:HB] <= cfg_data_i;
          gha_pkg::CfgMaskLow:  tmask_q[HB-1:0]  <= cfg_data_i;
          default:              key_q            <= key_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && q_op_i.cmd == gha_pkg::CmdRestart |=>
      out_valid_q && out_q.result_high == '0 && out_q.result_low == '0 && !ovf_q)
    else $error("restart did not clear state and result");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q && !(fire && q_op_i.cmd == gha_pkg::CmdRestart) |=> ovf_q)
    else $error("length error dropped without restart");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && q_op_i.cmd == gha_pkg::CmdFinal |=> acc_q == $past(acc_q) && out_q.is_tag)
    else $error("finalize disturbed the accumulator");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fire && q_op_i.cmd == gha_pkg::CmdRestart) |=>
      aad_q >= $past(aad_q) && txt_q >= $past(txt_q))
    else $error("byte counter went backward");

endmodule

/* hdl/ghash_authenticator.sv */
// channel   dir  handshake                    beat
// input     in   in_valid_i / in_stall_o      in_data_i  (gha_pkg::in_beat_t)
// output    out  out_valid_o / out_stall_i    out_data_o (gha_pkg::out_beat_t)
// config    in   cfg_we_i                     cfg_idx_i, cfg_data_i
//
// One beat per cycle while not stalled; a beat is queued, then its result is registered.
// The rate is set by the accumulator loop: one full GF(2^128) multiply per cycle while not stalled.
// Reset clears key, tag mask, accumulator, byte counters and error flag; no clearing pass.
// A stalled result holds in the output register; the queue of QDepth beats keeps
// accepting input until full, then in_stall_o rises.
module ghash_authenticator #(
  parameter int unsigned QDepth = gha_pkg::QueueDepth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  gha_pkg::in_beat_t            in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output gha_pkg::out_beat_t           out_data_o,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_idx_i,
  input  logic [gha_pkg::HalfBits-1:0] cfg_data_i
);

  logic         q_full, q_push, q_pop, q_valid;
  gha_pkg::op_t push_op, pop_op;

  gha_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_op_o     (push_op)
  );

  gha_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (q_push),
    .push_op_i (push_op),
    .full_o    (q_full),
    .pop_i     (q_pop),
    .valid_o   (q_valid),
    .pop_op_o  (pop_op)
  );

  gha_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .q_valid_i   (q_valid),
    .q_op_i      (pop_op),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* tb/sv/tb_top.sv */
class ghash_scoreboard;
  bit [127:0] hash_key;
  bit [127:0] tag_mask;
  bit [127:0] acc;
  bit [60:0]  aad_bytes;
  bit [60:0]  text_bytes;
  bit         overflow;
  gha_pkg::out_beat_t expected_q[$];
  int mismatches;

  function bit [127:0] gf_product(bit [127:0] x, bit [127:0] y);
    bit [127:0] r;
    bit [127:0] v;
    bit         lsb;
    r = '0;
    v = x;
    for (int i = 127; i >= 0; i--) begin
      if (y[i]) r ^= v;
      lsb = v[0];
      v = v >> 1;
      if (lsb) v[127:120] ^= 8'he1;
    end
    return r;
  endfunction

  function bit [60:0] count_up(bit [60:0] c, bit [4:0] n);
    bit [63:0] s;
    s = {3'b0, c} + 64'(n);
    if (s > {3'b0, gha_pkg::CntMax}) begin
      overflow = 1'b1;
      return gha_pkg::CntMax;
    end
    return s[60:0];
  endfunction

  function void set_register(logic [1:0] idx, bit [63:0] data);
    case (idx)
      gha_pkg::CfgKeyHigh:  hash_key[127:64] = data;
      gha_pkg::CfgKeyLow:   hash_key[63:0]   = data;
      gha_pkg::CfgMaskHigh: tag_mask[127:64] = data;
      gha_pkg::CfgMaskLow:  tag_mask[63:0]   = data;
      default: ;
    endcase
  endfunction

  function void note_beat(gha_pkg::in_beat_t b);
    bit [4:0]   nb;
    bit [127:0] keep;
    bit [127:0] blk;
    bit [127:0] len_blk;
    gha_pkg::out_beat_t e;
    nb = (b.byte_count > 16) ? 5'd16 : b.byte_count;
    e = '0;
    case (b.command)
      gha_pkg::CmdAad, gha_pkg::CmdText: begin
        keep = (nb == 0) ? '0 : ~({128{1'b1}} >> (8 * nb));
        blk = {b.block_high, b.block_low} & keep;
        acc = gf_product(acc ^ blk, hash_key);
        if (b.command == gha_pkg::CmdAad) aad_bytes = count_up(aad_bytes, nb);
        else text_bytes = count_up(text_bytes, nb);
        {e.result_high, e.result_low} = acc;
      end
      gha_pkg::CmdFinal: begin
        len_blk = {{3'b0, aad_bytes} << 3, {3'b0, text_bytes} << 3};
        {e.result_high, e.result_low} = gf_product(acc ^ len_blk, hash_key) ^ tag_mask;
        e.is_tag = 1'b1;
      end
      default: begin
        acc        = '0;
        aad_bytes  = '0;
        text_bytes = '0;
        overflow   = 1'b0;
      end
    endcase
    e.length_error = overflow;
    expected_q.push_back(e);
  endfunction

  function void check_beat(gha_pkg::out_beat_t got);
    gha_pkg::out_beat_t e;
    if (expected_q.size() == 0) begin
      if (mismatches < 10)
        $display("unexpected result %h_%h tag=%0b err=%0b",
                 got.result_high, got.result_low, got.is_tag, got.length_error);
      mismatches++;
      return;
    end
    e = expected_q.pop_front();
    if (got.result_high !== e.result_high || got.result_low !== e.result_low ||
        got.is_tag !== e.is_tag || got.length_error !== e.length_error) begin
      if (mismatches < 10)
        $display("mismatch: expected %h_%h tag=%0b err=%0b, got %h_%h tag=%0b err=%0b",
                 e.result_high, e.result_low, e.is_tag, e.length_error,
                 got.result_high, got.result_low, got.is_tag, got.length_error);
      mismatches++;
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QuietLimit = 2000;
  localparam int HoldCycles = 200;
  localparam int PhaseItems = 290;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  gha_pkg::in_beat_t  in_data_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  gha_pkg::out_beat_t out_data_o;
  logic               cfg_we_i    = 1'b0;
  logic [1:0]         cfg_idx_i   = '0;
  logic [63:0]        cfg_data_i  = '0;

  ghash_scoreboard sb = new();

  int tx_idle_pct  = 0;
  int rx_idle_pct  = 0;
  int hold_request = 0;
  int beats_sent   = 0;

  ghash_authenticator i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic bit [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic gha_pkg::in_beat_t beat_of(logic [1:0] cmd, bit [63:0] hi,
                                                bit [63:0] lo, int n);
    gha_pkg::in_beat_t b;
    b.command    = cmd;
    b.block_high = hi;
    b.block_low  = lo;
    b.byte_count = n[4:0];
    return b;
  endfunction

  function automatic gha_pkg::in_beat_t make_beat(logic [1:0] cmd, int n);
    return beat_of(cmd, rand64(), rand64(), n);
  endfunction

  task automatic send_beat(gha_pkg::in_beat_t b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_beat(b);
    beats_sent++;
  endtask

  task automatic write_register(logic [1:0] idx, bit [63:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.set_register(idx, data);
  endtask

  task automatic configure(bit [63:0] kh, bit [63:0] kl, bit [63:0] mh, bit [63:0] ml);
    write_register(gha_pkg::CfgKeyHigh, kh);
    write_register(gha_pkg::CfgKeyLow, kl);
    write_register(gha_pkg::CfgMaskHigh, mh);
    write_register(gha_pkg::CfgMaskLow, ml);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic send_message();
    int n_aad;
    int n_text;
    if ($urandom_range(99) < 80)
      send_beat(make_beat(gha_pkg::CmdRestart, $urandom_range(31)));
    n_aad  = $urandom_range(4);
    n_text = $urandom_range(8);
    for (int i = 0; i < n_aad; i++)
      send_beat(make_beat(gha_pkg::CmdAad, (i == n_aad - 1) ? $urandom_range(16, 1) : 16));
    for (int i = 0; i < n_text; i++)
      send_beat(make_beat(gha_pkg::CmdText, (i == n_text - 1) ? $urandom_range(16, 1) : 16));
    send_beat(make_beat(gha_pkg::CmdFinal, $urandom_range(31)));
    if ($urandom_range(99) < 20) send_beat(make_beat(gha_pkg::CmdFinal, $urandom_range(31)));
  endtask

  task automatic send_directed();
    send_beat(beat_of(gha_pkg::CmdRestart, '0, '0, 16));
    send_beat(beat_of(gha_pkg::CmdAad, '1, '1, 16));
    send_beat(beat_of(gha_pkg::CmdAad, '1, '1, 1));
    send_beat(beat_of(gha_pkg::CmdAad, '0, '0, 16));
    send_beat(make_beat(gha_pkg::CmdAad, 8));
    send_beat(make_beat(gha_pkg::CmdAad, 15));
    send_beat(make_beat(gha_pkg::CmdText, 7));
    send_beat(make_beat(gha_pkg::CmdText, 9));
    send_beat(beat_of(gha_pkg::CmdText, '1, '1, 0));
    send_beat(make_beat(gha_pkg::CmdText, 17));
    send_beat(beat_of(gha_pkg::CmdText, '1, '1, 31));
    send_beat(beat_of(gha_pkg::CmdFinal, '0, '0, 0));
    send_beat(beat_of(gha_pkg::CmdFinal, '1, '1, 31));
    send_beat(beat_of(gha_pkg::CmdRestart, '1, '1, 31));
    send_beat(make_beat(gha_pkg::CmdFinal, 16));
    send_beat(beat_of(gha_pkg::CmdText, '1, '1, 16));
    send_beat(make_beat(gha_pkg::CmdFinal, 1));
    send_beat(beat_of(gha_pkg::CmdRestart, '1, '1, 0));
    send_beat(beat_of(gha_pkg::CmdAad, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 12));
    send_beat(make_beat(gha_pkg::CmdFinal, 5));
  endtask

  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) sb.check_beat(out_data_o);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int target;
    bit held;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int p = 0; p < 6; p++) begin
      if (p < 2) begin
        tx_idle_pct = 36;
        rx_idle_pct = 72;
      end else if (p < 4) begin
        tx_idle_pct = 72;
        rx_idle_pct = 36;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      case (p)
        1: configure('0, '0, '1, '1);
        2: configure('1, '1, '0, '0);
        3: configure(64'h8000_0000_0000_0000, '0, rand64(), rand64());
        default: configure(rand64(), rand64(), rand64(), rand64());
      endcase
      if (p == 0) send_directed();
      target = beats_sent + PhaseItems;
      held   = 1'b0;
      while (beats_sent < target) begin
        if (!held && (p == 1 || p == 4) && beats_sent > target - PhaseItems / 2) begin
          hold_request = HoldCycles;
          held         = 1'b1;
        end
        if ($urandom_range(99) < 15)
          send_beat(make_beat(2'($urandom_range(3)), $urandom_range(31)));
        else send_message();
      end
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      wait_drained();
    end
    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
